[design/ewd_pkg.sv]
// ----------------------------------------------------------------------------
// ewd_pkg: shared definitions for the escalating watchdog
// Request kinds, control bytes, action codes, register indexes and the
// register set that the datapath reads.
// ----------------------------------------------------------------------------
`default_nettype none

package ewd_pkg;

  // Request kinds (slave tuser)
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TERM  = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  // Control bytes
  localparam logic [7:0] BYTE_KEEPALIVE = 8'h2E;  // '.'
  localparam logic [7:0] BYTE_ABORT     = 8'h71;  // 'q'

  // Actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_DUMP      = 3'd1;
  localparam logic [2:0] ACT_TERMINATE = 3'd2;
  localparam logic [2:0] ACT_KILL      = 3'd3;
  localparam logic [2:0] ACT_SELF      = 3'd4;

  // Escalation stages
  localparam logic [1:0] STAGE_IDLE = 2'd0;
  localparam logic [1:0] STAGE_DUMP = 2'd1;
  localparam logic [1:0] STAGE_TERM = 2'd2;
  localparam logic [1:0] STAGE_KILL = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_FIRST = 2'd0;
  localparam logic [1:0] REG_STAGE = 2'd1;
  localparam logic [1:0] REG_FINAL = 2'd2;

  // Register reset values
  localparam logic [15:0] FIRST_RESET = 16'd0;
  localparam logic [15:0] STAGE_RESET = 16'd10;
  localparam logic [15:0] FINAL_RESET = 16'd60;

  typedef struct packed {
    logic [15:0] first_timeout;
    logic [15:0] stage_timeout;
    logic [15:0] final_timeout;
  } ewd_regs_t;

endpackage

`default_nettype wire

[design/escalating_watchdog.sv]
// ----------------------------------------------------------------------------
// escalating_watchdog: four-stage escalating watchdog timer
// Counts ticks down from a programmable timeout and escalates through dump,
// terminate, kill and self-terminate; tick, start, keepalive, abort and
// terminate requests arrive as stream transactions, one result per request.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser: req_type; tdata: rx_byte
//  m_*       out        m_tvalid / m_tready  tdata: action, aborted, stage_now
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (16 bits)
//
//  One transaction per cycle sustained while m_tready stays high; an accepted
//  request is registered in the input register, then in the result register.
//  The stage/countdown next state is computed combinationally in ewd_core.
//  Reset (rst, synchronous) disarms the timer, clears the stage and loads
//  the default timeouts. A stalled m side holds its result; s_tready stays
//  high while the result register can drain in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module escalating_watchdog (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [2:0] action, [3] aborted, [5:4] stage_now
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  ewd_pkg::ewd_regs_t regs;

  logic       in_valid;
  logic [1:0] in_req;
  logic [7:0] in_byte;
  logic       take;
  logic [2:0] out_action;
  logic       out_aborted;
  logic [1:0] out_stage;

  ewd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // input register
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  ewd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .in_valid    (in_valid),
    .in_req      (in_req),
    .in_byte     (in_byte),
    .take        (take),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_action  (out_action),
    .out_aborted (out_aborted),
    .out_stage   (out_stage)
  );

  assign m_tdata = {2'b00, out_stage, out_aborted, out_action};

endmodule

`default_nettype wire

[design/ewd_cfg.sv]
// ----------------------------------------------------------------------------
// ewd_cfg: timeout register file
// Holds the three timeout registers, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ewd_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output ewd_pkg::ewd_regs_t     regs
);

  // always ready: a write is registered whenever cfg_valid is high
  assign cfg_ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.first_timeout <= ewd_pkg::FIRST_RESET;
      regs.stage_timeout <= ewd_pkg::STAGE_RESET;
      regs.final_timeout <= ewd_pkg::FINAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ewd_pkg::REG_FIRST: regs.first_timeout <= cfg_data;
        ewd_pkg::REG_STAGE: regs.stage_timeout <= cfg_data;
        ewd_pkg::REG_FINAL: regs.final_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/ewd_core.sv]
// ----------------------------------------------------------------------------
// ewd_core: watchdog state update and result register
// Applies one request to stage and countdown combinationally and loads
// the result register, which holds while the master side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ewd_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ewd_pkg::ewd_regs_t regs,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_req,
  input  wire logic [7:0]         in_byte,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_action,
  output logic                    out_aborted,
  output logic [1:0]              out_stage
);

  logic [1:0]  stage;
  logic [1:0]  stage_next;
  logic [15:0] countdown;
  logic [15:0] countdown_next;
  logic [15:0] count_dec;
  logic [2:0]  action_next;

  // item moves on when the result register is free or being drained
  assign take = in_valid && (!out_valid || out_ready);

  assign count_dec = countdown - 16'd1;

  // next stage, countdown and action for the pending request
  always_comb begin
    stage_next     = stage;
    countdown_next = countdown;
    action_next    = ewd_pkg::ACT_NONE;
    case (in_req)
      ewd_pkg::REQ_TICK: begin
        if (countdown != 16'd0) begin
          countdown_next = count_dec;
          if (count_dec == 16'd0) begin
            // expiry: fire the current stage and escalate
            case (stage)
              ewd_pkg::STAGE_IDLE: begin
                stage_next     = ewd_pkg::STAGE_DUMP;
                countdown_next = regs.stage_timeout;
                action_next    = ewd_pkg::ACT_DUMP;
              end
              ewd_pkg::STAGE_DUMP: begin
                stage_next     = ewd_pkg::STAGE_TERM;
                countdown_next = regs.stage_timeout;
                action_next    = ewd_pkg::ACT_TERMINATE;
              end
              ewd_pkg::STAGE_TERM: begin
                stage_next     = ewd_pkg::STAGE_KILL;
                countdown_next = regs.final_timeout;
                action_next    = ewd_pkg::ACT_KILL;
              end
              default: begin
                stage_next     = ewd_pkg::STAGE_KILL;
                countdown_next = 16'd0;
                action_next    = ewd_pkg::ACT_SELF;
              end
            endcase
          end
        end
      end
      ewd_pkg::REQ_BYTE: begin
        if (in_byte == ewd_pkg::BYTE_KEEPALIVE) begin
          countdown_next = regs.first_timeout;
        end else if (in_byte == ewd_pkg::BYTE_ABORT) begin
          // abort forces the terminate stage and fires it: always terminate
          stage_next     = ewd_pkg::STAGE_TERM;
          countdown_next = regs.stage_timeout;
          action_next    = ewd_pkg::ACT_TERMINATE;
        end
      end
      ewd_pkg::REQ_TERM: begin
        stage_next     = ewd_pkg::STAGE_TERM;
        countdown_next = regs.stage_timeout;
        action_next    = ewd_pkg::ACT_TERMINATE;
      end
      default: begin
        // start: rearm only, stage kept
        countdown_next = regs.first_timeout;
      end
    endcase
  end

  // watchdog state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ewd_pkg::STAGE_IDLE;
      countdown <= 16'd0;
    end else if (take) begin
      stage     <= stage_next;
      countdown <= countdown_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_action  <= action_next;
      out_aborted <= (stage_next != ewd_pkg::STAGE_IDLE);
      out_stage   <= stage_next;
    end
  end

endmodule

`default_nettype wire

[tb/sv/escalating_watchdog_tb.sv]
// ----------------------------------------------------------------------------
// escalating_watchdog_tb: self-checking bench for the escalating watchdog
// Streams tick, byte, terminate and start requests into the block, predicts
// each action and stage in a cycle-free model of the escalation, and compares
// every result transaction field by field. Timeouts are reprogrammed between
// phases. Both stream sides idle at random, and the result side is held off
// once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------

module escalating_watchdog_tb;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] rx;
  } wd_req_t;

  typedef struct {
    logic [2:0] action;
    logic       aborted;
    logic [1:0] stage_now;
  } wd_result_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [2:0] action, [3] aborted, [5:4] stage_now
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predicted timer state and timeout registers
  logic [15:0] to_first = ewd_pkg::FIRST_RESET;
  logic [15:0] to_stage = ewd_pkg::STAGE_RESET;
  logic [15:0] to_final = ewd_pkg::FINAL_RESET;
  logic [1:0]  wd_stage = ewd_pkg::STAGE_IDLE;
  logic [15:0] wd_count = '0;

  wd_req_t    req_backlog[$];
  wd_result_t expected_actions[$];
  wd_req_t    drv_item;
  wd_result_t mon_want;

  // Handshake bookkeeping
  logic        s_acc = 1'b0;
  logic        m_acc = 1'b0;
  logic        idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;

  // Run statistics
  int unsigned err_cnt = 0;
  int unsigned reqs_taken = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned fired[0:7];

  escalating_watchdog DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fire the action of the current stage and step to the next one
  function automatic logic [2:0] escalate();
    case (wd_stage)
      ewd_pkg::STAGE_IDLE: begin
        wd_stage = ewd_pkg::STAGE_DUMP;
        wd_count = to_stage;
        return ewd_pkg::ACT_DUMP;
      end
      ewd_pkg::STAGE_DUMP: begin
        wd_stage = ewd_pkg::STAGE_TERM;
        wd_count = to_stage;
        return ewd_pkg::ACT_TERMINATE;
      end
      ewd_pkg::STAGE_TERM: begin
        wd_stage = ewd_pkg::STAGE_KILL;
        wd_count = to_final;
        return ewd_pkg::ACT_KILL;
      end
      default: begin
        wd_stage = ewd_pkg::STAGE_KILL;
        wd_count = '0;
        return ewd_pkg::ACT_SELF;
      end
    endcase
  endfunction

  // Expected result of one request; updates the predicted state
  function automatic wd_result_t watchdog_predict(input logic [1:0] kind,
                                                  input logic [7:0] rx);
    wd_result_t r;
    r.action = ewd_pkg::ACT_NONE;
    case (kind)
      ewd_pkg::REQ_TICK: begin
        // a zero count is disarmed
        if (wd_count != 0) begin
          wd_count = wd_count - 16'd1;
          if (wd_count == 0) r.action = escalate();
        end
      end
      ewd_pkg::REQ_BYTE: begin
        if (rx == ewd_pkg::BYTE_KEEPALIVE) begin
          wd_count = to_first;
        end else if (rx == ewd_pkg::BYTE_ABORT) begin
          // abort always fires from the dump stage
          wd_stage = ewd_pkg::STAGE_DUMP;
          r.action = escalate();
        end
      end
      ewd_pkg::REQ_TERM: begin
        wd_stage = ewd_pkg::STAGE_TERM;
        wd_count = to_stage;
        r.action = ewd_pkg::ACT_TERMINATE;
      end
      default: wd_count = to_first;   // start keeps the stage
    endcase
    r.aborted = (wd_stage != ewd_pkg::STAGE_IDLE);
    r.stage_now = wd_stage;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             what, results_checked, got, want);
    err_cnt++;
  endtask

  task automatic queue_req(input logic [1:0] kind, input logic [7:0] rx);
    wd_req_t it;
    it.kind = kind;
    it.rx = rx;
    req_backlog.push_back(it);
  endtask

  // Random requests, mostly ticks so that armed timers run out
  task automatic add_random(input int n);
    int r;
    queue_req(ewd_pkg::REQ_START, 8'($urandom_range(0, 255)));
    for (int i = 1; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)      queue_req(ewd_pkg::REQ_TICK, 8'($urandom_range(0, 255)));
      else if (r < 63) queue_req(ewd_pkg::REQ_START, 8'($urandom_range(0, 255)));
      else if (r < 75) queue_req(ewd_pkg::REQ_BYTE, ewd_pkg::BYTE_KEEPALIVE);
      else if (r < 82) queue_req(ewd_pkg::REQ_BYTE, ewd_pkg::BYTE_ABORT);
      else if (r < 92) queue_req(ewd_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
      else             queue_req(ewd_pkg::REQ_TERM, 8'($urandom_range(0, 255)));
    end
  endtask

  // Wait until every request is sent and every result is back
  task automatic wait_idle();
    do @(posedge clk);
    while (req_backlog.size() != 0 || s_tvalid || expected_actions.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Request driver: one transaction at a time from the backlog
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_acc) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        drv_item = req_backlog.pop_front();
        s_tuser  <= drv_item.kind;
        s_tdata  <= drv_item.rx;
        s_tvalid <= 1'b1;
        send_gap = idle_on ? $urandom_range(0, 3) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_done != hold_asks) begin
      hold_done = hold_asks;
      hold_left = 60;
    end
    if (m_acc) stall_left = idle_on ? $urandom_range(0, 3) : 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: register writes, result checks, request prediction
  always @(posedge clk) begin
    if (rst) begin
      s_acc <= 1'b0;
      m_acc <= 1'b0;
      to_first = ewd_pkg::FIRST_RESET;
      to_stage = ewd_pkg::STAGE_RESET;
      to_final = ewd_pkg::FINAL_RESET;
      wd_stage = ewd_pkg::STAGE_IDLE;
      wd_count = '0;
    end else begin
      s_acc <= s_tvalid && s_tready;
      m_acc <= m_tvalid && m_tready;
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          ewd_pkg::REG_FIRST: to_first = cfg_data;
          ewd_pkg::REG_STAGE: to_stage = cfg_data;
          ewd_pkg::REG_FINAL: to_final = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_actions.size() == 0) begin
          report_mismatch("unexpected result transaction", m_tdata, 0);
        end else begin
          mon_want = expected_actions.pop_front();
          if (m_tdata[2:0] !== mon_want.action)
            report_mismatch("action", m_tdata[2:0], mon_want.action);
          if (m_tdata[3] !== mon_want.aborted)
            report_mismatch("aborted", m_tdata[3], mon_want.aborted);
          if (m_tdata[5:4] !== mon_want.stage_now)
            report_mismatch("stage_now", m_tdata[5:4], mon_want.stage_now);
          fired[mon_want.action]++;
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        expected_actions.push_back(watchdog_predict(s_tuser, s_tdata));
        reqs_taken++;
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [15:0] ph_first, ph_stage, ph_final;
    for (int i = 0; i < 8; i++) fired[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset timeouts: first timeout of zero keeps the timer disarmed
    queue_req(ewd_pkg::REQ_TICK, 8'h00);
    queue_req(ewd_pkg::REQ_START, 8'h00);
    queue_req(ewd_pkg::REQ_TICK, 8'hFF);
    queue_req(ewd_pkg::REQ_BYTE, 8'h00);
    queue_req(ewd_pkg::REQ_BYTE, 8'hFF);
    queue_req(ewd_pkg::REQ_BYTE, ewd_pkg::BYTE_KEEPALIVE);
    queue_req(ewd_pkg::REQ_TERM, 8'h00);
    queue_req(ewd_pkg::REQ_START, 8'hFF);
    queue_req(ewd_pkg::REQ_TICK, 8'h00);
    wait_idle();

    // Short timeouts: walk the full escalation, then abort and terminate
    write_reg(ewd_pkg::REG_FIRST, 16'd2);
    write_reg(ewd_pkg::REG_STAGE, 16'd1);
    write_reg(ewd_pkg::REG_FINAL, 16'd1);
    queue_req(ewd_pkg::REQ_START, 8'h00);
    repeat (6) queue_req(ewd_pkg::REQ_TICK, 8'h00);
    queue_req(ewd_pkg::REQ_BYTE, ewd_pkg::BYTE_ABORT);
    queue_req(ewd_pkg::REQ_BYTE, ewd_pkg::BYTE_ABORT);
    queue_req(ewd_pkg::REQ_BYTE, ewd_pkg::BYTE_KEEPALIVE);
    queue_req(ewd_pkg::REQ_TICK, 8'h00);
    queue_req(ewd_pkg::REQ_TICK, 8'h00);
    queue_req(ewd_pkg::REQ_TERM, 8'hFF);
    queue_req(ewd_pkg::REQ_TICK, ewd_pkg::BYTE_ABORT);   // byte ignored on a tick
    wait_idle();

    // Random phases, each under its own timeout setting
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin ph_first = 16'd3;     ph_stage = 16'd2;     ph_final = 16'd4;     end
        1: begin ph_first = 16'd0;     ph_stage = 16'd1;     ph_final = 16'd1;     end
        2: begin ph_first = 16'd1;     ph_stage = 16'd1;     ph_final = 16'd1;     end
        3: begin ph_first = 16'd5;     ph_stage = 16'd0;     ph_final = 16'd3;     end
        4: begin ph_first = 16'hFFFF;  ph_stage = 16'hFFFF;  ph_final = 16'hFFFF;  end
        5: begin ph_first = 16'd4;     ph_stage = 16'd3;     ph_final = 16'd0;     end
        default: begin
          ph_first = 16'($urandom_range(0, 6));
          ph_stage = 16'($urandom_range(1, 5));
          ph_final = 16'($urandom_range(1, 8));
        end
      endcase
      write_reg(ewd_pkg::REG_FIRST, ph_first);
      write_reg(ewd_pkg::REG_STAGE, ph_stage);
      write_reg(ewd_pkg::REG_FINAL, ph_final);
      idle_on = ($urandom_range(0, 2) != 0);
      add_random(75);
      // back up the block once with a long result stall
      if (ph == 3) hold_asks++;
      wait_idle();
    end

    if (expected_actions.size() != 0)
      report_mismatch("results still outstanding", expected_actions.size(), 0);
    $display("summary: %0d requests, %0d results checked, %0d register writes",
             reqs_taken, results_checked, cfg_writes);
    $display("summary: fired dump %0d, terminate %0d, kill %0d, self-terminate %0d",
             fired[ewd_pkg::ACT_DUMP], fired[ewd_pkg::ACT_TERMINATE],
             fired[ewd_pkg::ACT_KILL], fired[ewd_pkg::ACT_SELF]);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("timeout: %0d results still expected", expected_actions.size());
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
design/ewd_pkg.sv
design/ewd_cfg.sv
design/ewd_core.sv
design/escalating_watchdog.sv
tb/sv/escalating_watchdog_tb.sv
